// ===== src/eva_pkg.sv =====
// ----------------------------------------------------------------------------
// eva_pkg - shared types and constants for the elementwise vector ALU
// Operation codes, error codes, the result word, Q16.16 limits, the arctan
// table of the CORDIC stages and the saturation helper.
// ----------------------------------------------------------------------------
package eva_pkg;

	localparam int DW = 32;
	localparam int FW = 16;
	localparam int WIDE_W = 66;
	localparam int Z_W = 36;
	localparam int DIV_STEPS = DW + FW;
	localparam int ROOT_STEPS = DW;
	localparam int CORDIC_STEPS = 32;
	localparam int NORM_TOP = 60;

	localparam logic [DW-1:0] ONE_FX = DW'(1) << FW;
	localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [Z_W-1:0] PI_Q32 = 36'sd13493037705;
	localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1) << (FW - 1);

	typedef enum logic [3:0] {
		OP_PASS, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ATAN2, OP_MIN, OP_MAX,
		OP_MEAN, OP_GEOMEAN, OP_GE, OP_GT, OP_LE, OP_LT, OP_EQ, OP_NE
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE, ERR_DIV_ZERO, ERR_NEG_ROOT, ERR_SAT
	} err_t;

	typedef struct packed {
		logic [DW-1:0] value;
		err_t err;
	} res_t;

	// magnitude of a two's complement word (minimum maps to 2^(DW-1))
	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? (~v + DW'(1)) : v;
	endfunction

	// clamp a wide signed value to the word range and flag it
	function automatic res_t sat_w(input logic signed [WIDE_W-1:0] v);
		res_t r;
		r.value = v[DW-1:0];
		r.err = ERR_NONE;
		if (v[WIDE_W-1:DW-1] != {(WIDE_W-DW+1){v[DW-1]}}) begin
			r.value = v[WIDE_W-1] ? SAT_MIN : SAT_MAX;
			r.err = ERR_SAT;
		end
		return r;
	endfunction

	// atan(2^-i) in Q.32 radians
	function automatic logic [31:0] atan_q32(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0: t = 32'd3373259426;
			5'd1: t = 32'd1991351317;
			5'd2: t = 32'd1052175346;
			5'd3: t = 32'd534100635;
			5'd4: t = 32'd268086748;
			5'd5: t = 32'd134174063;
			5'd6: t = 32'd67103403;
			5'd7: t = 32'd33553749;
			5'd8: t = 32'd16777131;
			5'd9: t = 32'd8388597;
			5'd10: t = 32'd4194303;
			5'd11: t = 32'd2097152;
			5'd12: t = 32'd1048576;
			5'd13: t = 32'd524288;
			5'd14: t = 32'd262144;
			5'd15: t = 32'd131072;
			5'd16: t = 32'd65536;
			5'd17: t = 32'd32768;
			5'd18: t = 32'd16384;
			5'd19: t = 32'd8192;
			5'd20: t = 32'd4096;
			5'd21: t = 32'd2048;
			5'd22: t = 32'd1024;
			5'd23: t = 32'd512;
			5'd24: t = 32'd256;
			5'd25: t = 32'd128;
			5'd26: t = 32'd64;
			5'd27: t = 32'd32;
			5'd28: t = 32'd16;
			5'd29: t = 32'd8;
			5'd30: t = 32'd4;
			5'd31: t = 32'd2;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== src/eva_div.sv =====
// ----------------------------------------------------------------------------
// eva_div - pipelined fixed-point divider
// Restoring division of (|a| << FW) by |b|, one quotient bit per stage,
// then sign, divide-by-zero handling and saturation.
// ----------------------------------------------------------------------------
module eva_div (
	input logic clk,
	input logic [eva_pkg::DW-1:0] a,
	input logic [eva_pkg::DW-1:0] b,
	output eva_pkg::res_t res
);

	localparam int STEPS = eva_pkg::DIV_STEPS;
	localparam int DW = eva_pkg::DW;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [STEPS-1:0] num;
		logic [STEPS-1:0] quo;
		logic [DW-1:0] mb;
		logic na;
		logic neg;
		logic dz;
	} div_t;

	div_t div_s [0:STEPS];

	// one restoring step: bring down the next numerator bit, subtract if it fits
	function automatic div_t div_step(input div_t s);
		div_t r;
		logic [DW:0] trial;
		logic [DW:0] diff;
		r = s;
		trial = {s.rem, s.num[STEPS-1]};
		diff = trial - {1'b0, s.mb};
		r.num = s.num << 1;
		r.rem = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
		r.quo = {s.quo[STEPS-2:0], ~diff[DW]};
		return r;
	endfunction

	logic [eva_pkg::WIDE_W-1:0] q_wide;
	eva_pkg::res_t res_c;

	// load magnitudes, then advance every step stage
	always_ff @(posedge clk) begin
		div_s[0].rem <= '0;
		div_s[0].num <= {eva_pkg::mag(a), {eva_pkg::FW{1'b0}}};
		div_s[0].quo <= '0;
		div_s[0].mb <= eva_pkg::mag(b);
		div_s[0].na <= a[DW-1];
		div_s[0].neg <= a[DW-1] ^ b[DW-1];
		div_s[0].dz <= (b == '0);
		for (int k = 0; k < STEPS; k++) begin
			div_s[k+1] <= div_step(div_s[k]);
		end
	end

	// apply sign, catch divide by zero, saturate
	always_comb begin
		q_wide = {{(eva_pkg::WIDE_W-STEPS){1'b0}}, div_s[STEPS].quo};
		if (div_s[STEPS].neg) begin
			q_wide = ~q_wide + eva_pkg::WIDE_W'(1);
		end
		res_c = eva_pkg::sat_w($signed(q_wide));
		if (div_s[STEPS].dz) begin
			res_c.value = div_s[STEPS].na ? eva_pkg::SAT_MIN : eva_pkg::SAT_MAX;
			res_c.err = eva_pkg::ERR_DIV_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		res <= res_c;
	end

endmodule

// ===== src/eva_atan.sv =====
// ----------------------------------------------------------------------------
// eva_atan - pipelined CORDIC atan2(b, a)
// Magnitudes, leading-one search, normalization to bit 60, 32 vectoring
// stages, then quadrant fix and rounding to Q16.16.
// ----------------------------------------------------------------------------
module eva_atan (
	input logic clk,
	input logic [eva_pkg::DW-1:0] a,
	input logic [eva_pkg::DW-1:0] b,
	output eva_pkg::res_t res
);

	localparam int DW = eva_pkg::DW;
	localparam int STEPS = eva_pkg::CORDIC_STEPS;
	localparam int Z_W = eva_pkg::Z_W;

	typedef struct packed {
		logic na;
		logic nb;
		logic zr;
	} flg_t;

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [Z_W-1:0] z;
		flg_t f;
	} cd_t;

	logic [DW-1:0] mx_s1, my_s1, mx_s2, my_s2;
	flg_t f_s1, f_s2;
	logic [5:0] sh_s2;
	logic [4:0] top_c;
	logic [DW-1:0] m_c;
	cd_t cd_s [0:STEPS];

	// one vectoring step, rotating toward the x axis
	function automatic cd_t cd_step(input cd_t s, input int k);
		cd_t r;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [Z_W-1:0] t;
		r = s;
		dx = $signed(s.y) >>> k;
		dy = $signed(s.x) >>> k;
		t = $signed({4'b0, eva_pkg::atan_q32(5'(k))});
		if (!s.y[63]) begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + t;
		end else begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - t;
		end
		return r;
	endfunction

	// find the leading one of the larger magnitude
	always_comb begin
		m_c = mx_s1 | my_s1;
		top_c = '0;
		for (int j = 0; j < DW; j++) begin
			if (m_c[j]) begin
				top_c = 5'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		mx_s1 <= eva_pkg::mag(a);
		my_s1 <= eva_pkg::mag(b);
		f_s1.na <= a[DW-1];
		f_s1.nb <= b[DW-1];
		f_s1.zr <= (a == '0) && (b == '0);
		mx_s2 <= mx_s1;
		my_s2 <= my_s1;
		f_s2 <= f_s1;
		sh_s2 <= 6'(eva_pkg::NORM_TOP) - {1'b0, top_c};
		cd_s[0].x <= $signed(64'(mx_s2) << sh_s2);
		cd_s[0].y <= $signed(64'(my_s2) << sh_s2);
		cd_s[0].z <= '0;
		cd_s[0].f <= f_s2;
		for (int k = 0; k < STEPS; k++) begin
			cd_s[k+1] <= cd_step(cd_s[k], k);
		end
	end

	logic signed [Z_W-1:0] zc, theta;
	logic [Z_W-1:0] rsum;
	logic [eva_pkg::WIDE_W-1:0] w_c;
	eva_pkg::res_t res_c;

	// fix the quadrant, round half up to FW bits, apply sign of b
	always_comb begin
		zc = cd_s[STEPS].z[Z_W-1] ? '0 : cd_s[STEPS].z;
		theta = cd_s[STEPS].f.na ? (eva_pkg::PI_Q32 - zc) : zc;
		rsum = theta + eva_pkg::ROUND_HALF;
		w_c = {{(eva_pkg::WIDE_W-Z_W+eva_pkg::FW){1'b0}}, rsum[Z_W-1:eva_pkg::FW]};
		if (cd_s[STEPS].f.nb) begin
			w_c = ~w_c + eva_pkg::WIDE_W'(1);
		end
		res_c = eva_pkg::sat_w($signed(w_c));
		if (cd_s[STEPS].f.zr) begin
			res_c.value = '0;
			res_c.err = eva_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk) begin
		res <= res_c;
	end

endmodule

// ===== src/elementwise_vector_alu.sv =====
// ----------------------------------------------------------------------------
// elementwise_vector_alu - Q16.16 two-operand arithmetic unit
// One operand pair in, one result out, under the operation held in the
// configuration register.
// ----------------------------------------------------------------------------
// A pair is taken on every clock edge with start high; busy never rises, so
// the unit accepts one pair per cycle without gaps. Every result leaves on a
// single-cycle done strobe, in order; the receiver must capture it then.
// Every operation takes as long as the 48-stage divider, one quotient bit
// per stage; the faster paths are delayed to match. cfg_ready stays low
// while any pair is in flight or start is high, so the operation only
// changes between streams. error_code gives 1 on divide by zero, 2 on a
// negative geometric-mean product and 3 on saturation.
// ----------------------------------------------------------------------------
module elementwise_vector_alu (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] operand_a,
	input logic signed [31:0] operand_b,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [3:0] cfg_data,
	output logic done,
	output logic signed [31:0] result_value,
	output logic [1:0] error_code
);

	localparam int DW = eva_pkg::DW;
	localparam int RSTEPS = eva_pkg::ROOT_STEPS;
	localparam int OUT_LAT = 50;
	localparam int EARLY_DLY = 32;
	localparam int MID_DLY = 14;

	typedef struct packed {
		logic [33:0] rem;
		logic [DW-1:0] root;
		logic [2*DW-1:0] n;
		logic neg;
	} rt_t;

	eva_pkg::op_t op_q;
	logic accept;
	logic [OUT_LAT:0] vld_s;
	logic [DW-1:0] a_s1, b_s1;

	assign busy = 1'b0;
	assign cfg_ready = ~(|vld_s) & ~start;
	assign accept = start & ~busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= eva_pkg::OP_PASS;
		end else if (cfg_valid && cfg_ready) begin
			op_q <= eva_pkg::op_t'(cfg_data);
		end
	end

	// valid bits travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done <= 1'b0;
		end else begin
			vld_s <= {vld_s[OUT_LAT-1:0], accept};
			done <= vld_s[OUT_LAT];
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= operand_a;
		b_s1 <= operand_b;
	end

	// simple operations, computed combinationally
	logic signed [DW:0] sum_c, dif_c;
	logic signed [DW-1:0] sa, sb;
	eva_pkg::res_t simp_c, simp_s2, simp_s3, simp_s4;

	always_comb begin
		sa = $signed(a_s1);
		sb = $signed(b_s1);
		sum_c = {sa[DW-1], sa} + {sb[DW-1], sb};
		dif_c = {sa[DW-1], sa} - {sb[DW-1], sb};
		simp_c.value = a_s1;
		simp_c.err = eva_pkg::ERR_NONE;
		case (op_q)
			eva_pkg::OP_ADD: simp_c = eva_pkg::sat_w(eva_pkg::WIDE_W'(sum_c));
			eva_pkg::OP_SUB: simp_c = eva_pkg::sat_w(eva_pkg::WIDE_W'(dif_c));
			eva_pkg::OP_MIN: simp_c.value = (sa > sb) ? b_s1 : a_s1;
			eva_pkg::OP_MAX: simp_c.value = (sa < sb) ? b_s1 : a_s1;
			eva_pkg::OP_MEAN: simp_c.value = sum_c[DW:1];
			eva_pkg::OP_GE: simp_c.value = (sa >= sb) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_GT: simp_c.value = (sa > sb) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_LE: simp_c.value = (sa <= sb) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_LT: simp_c.value = (sa < sb) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_EQ: simp_c.value = (sa == sb) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_NE: simp_c.value = (sa != sb) ? eva_pkg::ONE_FX : '0;
			default: simp_c.value = a_s1;
		endcase
	end

	// magnitude product, shared by multiply and geometric mean
	logic [DW-1:0] ma_s2, mb_s2;
	logic mneg_s2, gneg_s2, mneg_s3;
	rt_t rt_s [0:RSTEPS];

	// one square-root digit: two product bits in, one root bit out
	function automatic rt_t rt_step(input rt_t s);
		rt_t r;
		logic [36:0] cur;
		logic [36:0] trial;
		logic [36:0] diff;
		r = s;
		cur = {1'b0, s.rem, s.n[2*DW-1:2*DW-2]};
		trial = {3'b0, s.root, 2'b01};
		diff = cur - trial;
		r.n = s.n << 2;
		r.rem = diff[36] ? cur[33:0] : diff[33:0];
		r.root = {s.root[DW-2:0], ~diff[36]};
		return r;
	endfunction

	always_ff @(posedge clk) begin
		simp_s2 <= simp_c;
		simp_s3 <= simp_s2;
		simp_s4 <= simp_s3;
		ma_s2 <= eva_pkg::mag(a_s1);
		mb_s2 <= eva_pkg::mag(b_s1);
		mneg_s2 <= a_s1[DW-1] ^ b_s1[DW-1];
		gneg_s2 <= (a_s1[DW-1] ^ b_s1[DW-1]) && (a_s1 != '0) && (b_s1 != '0);
		mneg_s3 <= mneg_s2;
		rt_s[0].rem <= '0;
		rt_s[0].root <= '0;
		rt_s[0].n <= ma_s2 * mb_s2;
		rt_s[0].neg <= gneg_s2;
		for (int k = 0; k < RSTEPS; k++) begin
			rt_s[k+1] <= rt_step(rt_s[k]);
		end
	end

	// multiply: sign, floor shift by FW, saturate
	logic [eva_pkg::WIDE_W-1:0] pw_c;
	eva_pkg::res_t mul_s4, root_c, root_q;

	always_comb begin
		pw_c = {2'b0, rt_s[0].n};
		if (mneg_s3) begin
			pw_c = ~pw_c + eva_pkg::WIDE_W'(1);
		end
	end

	// geometric mean: drop negative products, saturate the root
	always_comb begin
		root_c = eva_pkg::sat_w($signed({{(eva_pkg::WIDE_W-DW){1'b0}},
			rt_s[RSTEPS].root}));
		if (rt_s[RSTEPS].neg) begin
			root_c.value = '0;
			root_c.err = eva_pkg::ERR_NEG_ROOT;
		end
	end

	always_ff @(posedge clk) begin
		mul_s4 <= eva_pkg::sat_w($signed(pw_c) >>> eva_pkg::FW);
		root_q <= root_c;
	end

	// long-latency units
	eva_pkg::res_t atan_res, div_res;

	eva_atan u_atan (
		.clk (clk),
		.a   (a_s1),
		.b   (b_s1),
		.res (atan_res)
	);

	eva_div u_div (
		.clk (clk),
		.a   (a_s1),
		.b   (b_s1),
		.res (div_res)
	);

	// merge the paths as they finish, delaying earlier ones to match
	eva_pkg::res_t early_c, mid_c, mid_q, late_c, fin_c;
	eva_pkg::res_t early_d [1:EARLY_DLY];
	eva_pkg::res_t late_d [1:MID_DLY];

	always_comb begin
		early_c = (op_q == eva_pkg::OP_MUL) ? mul_s4 : simp_s4;
		mid_c = (op_q == eva_pkg::OP_GEOMEAN) ? root_q : early_d[EARLY_DLY];
		late_c = (op_q == eva_pkg::OP_ATAN2) ? atan_res : mid_q;
		fin_c = (op_q == eva_pkg::OP_DIV) ? div_res : late_d[MID_DLY];
	end

	always_ff @(posedge clk) begin
		early_d[1] <= early_c;
		for (int k = 2; k <= EARLY_DLY; k++) begin
			early_d[k] <= early_d[k-1];
		end
		mid_q <= mid_c;
		late_d[1] <= late_c;
		for (int k = 2; k <= MID_DLY; k++) begin
			late_d[k] <= late_d[k-1];
		end
		result_value <= $signed(fin_c.value);
		error_code <= fin_c.err;
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the Q16.16 elementwise ALU
// Drives operand pairs under every operation, predicts each result word and
// its error code in the bench, and compares them with the strobed outputs.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_LIMIT = 5000;
	localparam int PIPE_TAIL = 60;
	localparam int RAND_ITEMS = 500;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_data;
	logic done;
	logic signed [31:0] result_value;
	logic [1:0] error_code;

	eva_pkg::res_t expected_q[$];
	eva_pkg::op_t op_shadow;
	int mismatches;
	int words_sent;
	int words_checked;
	int idle_cycles;
	int burst_left;
	bit op_seen[16];

	elementwise_vector_alu u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.done(done),
		.result_value(result_value),
		.error_code(error_code)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// atan(2^-i) in Q.32 radians
	localparam longint ATAN_TAB[32] = '{
		64'sd3373259426, 1991351317, 1052175346, 534100635, 268086748, 134174063,
		67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576,
		524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	// clamp a signed 64-bit value to the 32-bit word
	function automatic eva_pkg::res_t clamp_word(input longint v, input eva_pkg::err_t e);
		eva_pkg::res_t r;
		r.err = e;
		if (v > 64'sd2147483647) begin
			r.value = eva_pkg::SAT_MAX;
			r.err = eva_pkg::ERR_SAT;
		end else if (v < -64'sd2147483648) begin
			r.value = eva_pkg::SAT_MIN;
			r.err = eva_pkg::ERR_SAT;
		end else begin
			r.value = v[31:0];
		end
		return r;
	endfunction

	// fixed-point arctangent of b over a, CORDIC vectoring
	function automatic eva_pkg::res_t atan2_word(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint unsigned mx, my, m;
		longint x, y, z, dx, dy, theta, r;
		eva_pkg::res_t res;
		mx = (a < 0) ? -longint'(a) : longint'(a);
		my = (b < 0) ? -longint'(b) : longint'(b);
		res.value = '0;
		res.err = eva_pkg::ERR_NONE;
		if ((mx | my) == 0)
			return res;
		m = mx | my;
		while (m >= (64'd1 << 61)) begin
			mx >>= 1; my >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 60)) begin
			mx <<= 1; my <<= 1; m <<= 1;
		end
		x = longint'(mx);
		y = longint'(my);
		z = 0;
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		if (z < 0)
			z = 0;
		theta = (a < 0) ? longint'(eva_pkg::PI_Q32) - z : z;
		r = (theta + (64'sd1 <<< 15)) >>> 16;
		return clamp_word((b < 0) ? -r : r, eva_pkg::ERR_NONE);
	endfunction

	// expected word for one operand pair under one operation
	function automatic eva_pkg::res_t alu_predict(input eva_pkg::op_t op,
			input logic signed [31:0] a, input logic signed [31:0] b);
		eva_pkg::res_t res;
		longint unsigned ma, mb, quo, prod, root, trial;
		longint p;
		res.value = '0;
		res.err = eva_pkg::ERR_NONE;
		ma = (a < 0) ? -longint'(a) : longint'(a);
		mb = (b < 0) ? -longint'(b) : longint'(b);
		case (op)
			eva_pkg::OP_PASS: res.value = a;
			eva_pkg::OP_ADD: res = clamp_word(longint'(a) + longint'(b), eva_pkg::ERR_NONE);
			eva_pkg::OP_SUB: res = clamp_word(longint'(a) - longint'(b), eva_pkg::ERR_NONE);
			eva_pkg::OP_MUL: begin
				p = longint'(a) * longint'(b);
				res = clamp_word(p >>> eva_pkg::FW, eva_pkg::ERR_NONE);
			end
			eva_pkg::OP_DIV: begin
				if (mb == 0) begin
					res.value = (a < 0) ? eva_pkg::SAT_MIN : eva_pkg::SAT_MAX;
					res.err = eva_pkg::ERR_DIV_ZERO;
				end else begin
					quo = (ma << eva_pkg::FW) / mb;
					p = longint'(quo);
					res = clamp_word(((a < 0) != (b < 0)) ? -p : p, eva_pkg::ERR_NONE);
				end
			end
			eva_pkg::OP_ATAN2: res = atan2_word(a, b);
			eva_pkg::OP_MIN: res.value = (a > b) ? b : a;
			eva_pkg::OP_MAX: res.value = (a < b) ? b : a;
			eva_pkg::OP_MEAN: begin
				p = (longint'(a) + longint'(b)) >>> 1;
				res.value = p[31:0];
			end
			eva_pkg::OP_GEOMEAN: begin
				if (((a < 0) != (b < 0)) && ma != 0 && mb != 0) begin
					res.err = eva_pkg::ERR_NEG_ROOT;
				end else begin
					prod = ma * mb;
					root = 0;
					for (int k = 31; k >= 0; k--) begin
						trial = root | (64'd1 << k);
						if (trial * trial <= prod)
							root = trial;
					end
					res = clamp_word(longint'(root), eva_pkg::ERR_NONE);
				end
			end
			eva_pkg::OP_GE: res.value = (a >= b) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_GT: res.value = (a > b) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_LE: res.value = (a <= b) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_LT: res.value = (a < b) ? eva_pkg::ONE_FX : '0;
			eva_pkg::OP_EQ: res.value = (a == b) ? eva_pkg::ONE_FX : '0;
			default: res.value = (a != b) ? eva_pkg::ONE_FX : '0;
		endcase
		return res;
	endfunction

	// track the register, predict accepted words, check strobed results
	always @(posedge clk) begin
		eva_pkg::res_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				op_shadow <= eva_pkg::op_t'(cfg_data);
			if (start && !busy) begin
				expected_q.push_back(alu_predict(op_shadow, operand_a, operand_b));
				op_seen[op_shadow] = 1'b1;
				words_sent++;
			end
			if (done) begin
				words_checked++;
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d with no word pending", $realtime,
							result_value);
				end else begin
					want = expected_q.pop_front();
					if (result_value !== want.value || error_code !== want.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: got value %h err %0d, want value %h err %0d",
								$realtime, result_value, error_code, want.value, want.err);
					end
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// send one word, inserting a random gap at the end of each burst
	task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			@(negedge clk);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		start = 1'b1;
		operand_a = a;
		operand_b = b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// hold until every pending word has come back, then let the pipe settle
	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (PIPE_TAIL) @(negedge clk);
	endtask

	task automatic write_op(input eva_pkg::op_t op);
		drain();
		cfg_valid = 1'b1;
		cfg_data = op;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_operand;
		case ($urandom_range(0, 7))
			0: return eva_pkg::SAT_MIN;
			1: return eva_pkg::SAT_MAX;
			2: return 32'($signed($urandom_range(0, 8)) - 4) <<< eva_pkg::FW;
			3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			4: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
			default: return $urandom();
		endcase
	endfunction

	// pass at reset value of the register
	task automatic test_reset_op;
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MAX);
		send_pair(eva_pkg::SAT_MAX, 32'sd0);
	endtask

	// corner cases of each arithmetic operation
	task automatic test_corners;
		write_op(eva_pkg::OP_ADD);
		send_pair(eva_pkg::SAT_MAX, 32'sd1);
		send_pair(eva_pkg::SAT_MIN, -32'sd1);
		write_op(eva_pkg::OP_SUB);
		send_pair(eva_pkg::SAT_MIN, 32'sd1);
		send_pair(32'sd0, eva_pkg::SAT_MIN);
		write_op(eva_pkg::OP_MUL);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MIN);
		send_pair(-32'sd1, 32'sd1);
		write_op(eva_pkg::OP_DIV);
		send_pair(32'sd5, 32'sd0);
		send_pair(-32'sd5, 32'sd0);
		send_pair(32'sd0, 32'sd0);
		send_pair(eva_pkg::SAT_MAX, 32'sd1);
		send_pair(-32'sd7, 32'sd3);
		write_op(eva_pkg::OP_ATAN2);
		send_pair(32'sd0, 32'sd0);
		send_pair(-32'sd3, 32'sd0);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MIN);
		write_op(eva_pkg::OP_MEAN);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MIN);
		send_pair(-32'sd1, 32'sd0);
		write_op(eva_pkg::OP_GEOMEAN);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MIN);
		send_pair(-32'sd4, 32'sd9);
		send_pair(-32'sd4, 32'sd0);
		write_op(eva_pkg::OP_EQ);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MIN);
		send_pair(eva_pkg::SAT_MIN, eva_pkg::SAT_MAX);
	endtask

	// random phases over every operation, each operation in turn first
	task automatic test_random_ops;
		int n;
		eva_pkg::op_t op;
		n = 0;
		for (int ph = 0; n < RAND_ITEMS; ph++) begin
			if (ph < 16)
				op = eva_pkg::op_t'(ph);
			else
				op = eva_pkg::op_t'($urandom_range(0, 15));
			write_op(op);
			repeat ($urandom_range(20, 40)) begin
				if ($urandom_range(0, 9) == 0) begin
					logic [31:0] v;
					v = rand_operand();
					send_pair(v, v);
				end else begin
					send_pair(rand_operand(), rand_operand());
				end
				n++;
			end
		end
		write_op(eva_pkg::OP_PASS);
	endtask

	initial begin
		int covered;
		arst_n = 1'b0;
		start = 1'b0;
		operand_a = '0;
		operand_b = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		op_shadow = eva_pkg::OP_PASS;
		mismatches = 0;
		words_sent = 0;
		words_checked = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_op();
		test_corners();
		test_random_ops();

		drain();
		covered = 0;
		foreach (op_seen[i])
			if (op_seen[i])
				covered++;
		$display("Sent %0d operand words under %0d of 16 operations, checked %0d results.",
			words_sent, covered, words_checked);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Mismatches: %0d", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
